/* design/psv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psv_pkg
// types and constants shared by the producer sequence validator
// ----------------------------------------------------------------------------
package psv_pkg;

	localparam int KEY_W = 32;
	localparam int NUM_W = 63;

	typedef enum logic [2:0] {
		ST_ACCEPTED      = 3'd0,
		ST_DUPLICATE     = 3'd1,
		ST_STALE         = 3'd2,
		ST_BAD_EPOCH_SEQ = 3'd3,
		ST_GAP           = 3'd4,
		ST_CLOSED        = 3'd5,
		ST_FULL          = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_LAUNCH,
		FSM_SCAN
	} fsm_t;

	// lookup token handed from cell to cell
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic             free_seen;
		logic [NUM_W-1:0] epoch;
		logic [NUM_W-1:0] prior_seq;
	} token_t;

	// write-back broadcast to every cell
	typedef struct packed {
		logic             en;
		logic             hit;
		logic [NUM_W-1:0] epoch;
		logic [NUM_W-1:0] seq;
	} wrback_t;

endpackage
`default_nettype wire

/* design/psv_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psv_cell
// one producer table entry; checks the passing token and takes write-back
// ----------------------------------------------------------------------------
module psv_cell
	import psv_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [KEY_W-1:0] key_in,
	input  wire token_t           tok_in,
	input  wire wrback_t          wr,
	output token_t                tok_out
);

	logic             valid_q;
	logic             claim_q;
	logic [KEY_W-1:0] key_q;
	logic [NUM_W-1:0] epoch_q;
	logic [NUM_W-1:0] seq_q;
	token_t           tok_q;
	token_t           tok_d;
	logic             hit_here;
	logic             wr_here;

	assign hit_here = valid_q && (key_q == key_in);
	assign wr_here  = wr.en && (wr.hit ? hit_here : claim_q);

	always_comb begin
		tok_d           = tok_in;
		tok_d.hit       = tok_in.hit | hit_here;
		tok_d.free_seen = tok_in.free_seen | ~valid_q;
		if (!tok_in.hit) begin
			tok_d.epoch     = epoch_q;
			tok_d.prior_seq = seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			claim_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			tok_q <= tok_d;
			// lowest free entry claims a possible insert
			if (tok_in.vld) begin
				claim_q <= ~valid_q & ~tok_in.free_seen;
			end
			if (wr_here) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			key_q   <= key_in;
			epoch_q <= wr.epoch;
			seq_q   <= wr.seq;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

/* design/producer_sequence_validator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// producer_sequence_validator
// checks producer writes for epoch and sequence order against a producer table
// ----------------------------------------------------------------------------
// the start transfer is registered, the FSM launches a lookup token that walks the
//   chain of entry cells one cell a cycle, and done is registered from the tail;
//   busy stays up until then, so a new write is taken only after the last is done
// reset: table empty and stream open; results cannot be stalled by the receiver
module producer_sequence_validator
	import psv_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [KEY_W-1:0] producer_key,
	input  wire logic [NUM_W-1:0] epoch,
	input  wire logic [NUM_W-1:0] seq,
	input  wire logic             commit,
	input  wire logic             close_request,
	output logic                  done,
	output logic [2:0]            status,
	output logic [NUM_W-1:0]      next_seq,
	output logic [NUM_W-1:0]      got_seq,
	output logic [NUM_W-1:0]      stored_epoch,
	output logic [NUM_W-1:0]      prior_seq,
	output logic                  was_closed,
	output logic                  now_closed
);

	fsm_t             state_q;
	fsm_t             state_d;
	logic             accept;
	logic             decide;
	token_t           tok [0:TABLE_DEPTH];
	token_t           tail;
	wrback_t          wr;

	logic [KEY_W-1:0] key_q;
	logic [NUM_W-1:0] epoch_q;
	logic [NUM_W-1:0] seq_q;
	logic             commit_q;
	logic             close_q;

	logic             closed_q;
	logic             closer_valid_q;
	logic [KEY_W-1:0] closer_key_q;
	logic [NUM_W-1:0] closer_epoch_q;
	logic [NUM_W-1:0] closer_seq_q;

	status_t          st_d;
	logic [NUM_W-1:0] exp_d;
	logic [NUM_W-1:0] rcv_d;
	logic [NUM_W-1:0] cur_d;
	logic [NUM_W-1:0] last_d;
	logic [NUM_W-1:0] nxt;
	logic             do_close;

	logic             done_q;
	status_t          status_q;
	logic [NUM_W-1:0] exp_q;
	logic [NUM_W-1:0] rcv_q;
	logic [NUM_W-1:0] cur_q;
	logic [NUM_W-1:0] last_q;
	logic             was_closed_q;
	logic             now_closed_q;

	assign accept = start && !busy;
	assign tail   = tok[TABLE_DEPTH];
	assign decide = (state_q == FSM_SCAN) && tail.vld;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE:   if (start) state_d = FSM_LAUNCH;
			FSM_LAUNCH: state_d = FSM_SCAN;
			FSM_SCAN:   if (tail.vld) state_d = FSM_IDLE;
			default:    state_d = FSM_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		busy         = 1'b1;
		tok[0]       = '0;
		unique case (state_q)
			FSM_IDLE:   busy = 1'b0;
			FSM_LAUNCH: tok[0].vld = 1'b1;
			FSM_SCAN:   busy = 1'b1;
			default:    busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= producer_key;
			epoch_q  <= epoch;
			seq_q    <= seq;
			commit_q <= commit;
			close_q  <= close_request;
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		psv_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.key_in (key_q),
			.tok_in (tok[i]),
			.wr     (wr),
			.tok_out(tok[i+1])
		);
	end

	assign nxt = tail.prior_seq + 1'b1;

	always_comb begin
		st_d     = ST_ACCEPTED;
		exp_d    = '0;
		rcv_d    = '0;
		cur_d    = '0;
		last_d   = '0;
		do_close = 1'b0;
		wr.en    = 1'b0;
		wr.hit   = tail.hit;
		wr.epoch = epoch_q;
		wr.seq   = seq_q;
		if (closed_q) begin
			if (closer_valid_q && closer_key_q == key_q && closer_epoch_q == epoch_q &&
			    closer_seq_q == seq_q) begin
				st_d   = ST_DUPLICATE;
				last_d = seq_q;
			end else begin
				st_d = ST_CLOSED;
			end
		end else begin
			if (!tail.hit) begin
				if (seq_q != '0) begin
					st_d  = ST_GAP;
					rcv_d = seq_q;
				end
			end else if (epoch_q < tail.epoch) begin
				st_d  = ST_STALE;
				cur_d = tail.epoch;
			end else if (epoch_q > tail.epoch) begin
				if (seq_q != '0) begin
					st_d = ST_BAD_EPOCH_SEQ;
				end
			end else if (seq_q <= tail.prior_seq) begin
				st_d   = ST_DUPLICATE;
				last_d = tail.prior_seq;
			end else if (seq_q != nxt) begin
				st_d  = ST_GAP;
				exp_d = nxt;
				rcv_d = seq_q;
			end
			if (st_d == ST_ACCEPTED && (commit_q || close_q)) begin
				if (!tail.hit && !tail.free_seen) begin
					st_d = ST_FULL;
				end else begin
					wr.en    = decide;
					do_close = close_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q       <= 1'b0;
			closer_valid_q <= 1'b0;
			closer_key_q   <= '0;
			closer_epoch_q <= '0;
			closer_seq_q   <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= decide;
			if (decide && do_close) begin
				closed_q       <= 1'b1;
				closer_valid_q <= 1'b1;
				closer_key_q   <= key_q;
				closer_epoch_q <= epoch_q;
				closer_seq_q   <= seq_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			status_q     <= st_d;
			exp_q        <= exp_d;
			rcv_q        <= rcv_d;
			cur_q        <= cur_d;
			last_q       <= last_d;
			was_closed_q <= closed_q;
			now_closed_q <= closed_q | do_close;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign next_seq     = exp_q;
	assign got_seq      = rcv_q;
	assign stored_epoch = cur_q;
	assign prior_seq    = last_q;
	assign was_closed   = was_closed_q;
	assign now_closed   = now_closed_q;

endmodule
`default_nettype wire

/* design/psv_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psv_checker
// port-level checks of the producer sequence validator
// ----------------------------------------------------------------------------
module psv_checker
	import psv_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [2:0] status,
	input wire logic       was_closed,
	input wire logic       now_closed
);

	// a start transfer makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("no busy after start transfer");

	// a result ends the item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// a closed stream stays closed
	a_stay_closed: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_closed |-> now_closed)
		else $error("stream reopened");

	// closing needs an accepted write
	a_close_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && !was_closed && now_closed |-> status == ST_ACCEPTED)
		else $error("stream closed by refused write");

	// a closed stream only gives duplicate or closed
	a_closed_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && was_closed |-> status == ST_DUPLICATE || status == ST_CLOSED)
		else $error("bad status on closed stream");

endmodule

bind producer_sequence_validator psv_checker u_psv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.was_closed(was_closed),
	.now_closed(now_closed)
);
`default_nettype wire

/* tb/producer_sequence_validator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// producer_sequence_validator_tb
// Self-checking bench for the producer sequence validator. Producer writes go
// in over the start/busy handshake. A behavioral copy of the producer table and
// the close record works out the verdict of every accepted write, and each
// done strobe is compared field by field with the oldest verdict still due.
// Directed writes cover the edge cases. Random traffic is mostly in-order
// sequences with some broken or noisy writes, then the table is filled, and
// the stream is closed last because nothing reopens it.
// ----------------------------------------------------------------------------
module producer_sequence_validator_tb;
	import psv_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [NUM_W-1:0] NUM_MAX = '1;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		status_t          status;
		logic [NUM_W-1:0] next_seq;
		logic [NUM_W-1:0] got_seq;
		logic [NUM_W-1:0] stored_epoch;
		logic [NUM_W-1:0] prior_seq;
		logic             was_closed;
		logic             now_closed;
	} verdict_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [KEY_W-1:0] producer_key;
	logic [NUM_W-1:0] epoch;
	logic [NUM_W-1:0] seq;
	logic             commit;
	logic             close_request;
	logic             done;
	logic [2:0]       status;
	logic [NUM_W-1:0] next_seq;
	logic [NUM_W-1:0] got_seq;
	logic [NUM_W-1:0] stored_epoch;
	logic [NUM_W-1:0] prior_seq;
	logic             was_closed;
	logic             now_closed;

	// producer table and close record as the testbench sees them
	logic             tbl_valid [DEPTH];
	logic [KEY_W-1:0] tbl_key   [DEPTH];
	logic [NUM_W-1:0] tbl_epoch [DEPTH];
	logic [NUM_W-1:0] tbl_last  [DEPTH];
	logic             strm_closed;
	logic             closer_valid;
	logic [KEY_W-1:0] closer_key;
	logic [NUM_W-1:0] closer_epoch;
	logic [NUM_W-1:0] closer_seq;

	verdict_t         verdicts_due [$];
	logic [KEY_W-1:0] key_pool [$];
	int               idle_pct;
	int               errors;
	int               cycles;

	producer_sequence_validator #(.TABLE_DEPTH(DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.producer_key  (producer_key),
		.epoch         (epoch),
		.seq           (seq),
		.commit        (commit),
		.close_request (close_request),
		.done          (done),
		.status        (status),
		.next_seq      (next_seq),
		.got_seq       (got_seq),
		.stored_epoch  (stored_epoch),
		.prior_seq     (prior_seq),
		.was_closed    (was_closed),
		.now_closed    (now_closed)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [NUM_W-1:0] rand_num();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[NUM_W-1:0];
	endfunction

	function automatic int lookup_slot(logic [KEY_W-1:0] key);
		int i;
		for (i = 0; i < DEPTH; i++)
			if (tbl_valid[i] && tbl_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic int entries_used();
		int i;
		int n;
		n = 0;
		for (i = 0; i < DEPTH; i++)
			if (tbl_valid[i])
				n++;
		return n;
	endfunction

	function automatic verdict_t judge_write(logic [KEY_W-1:0] key, logic [NUM_W-1:0] ep,
			logic [NUM_W-1:0] sq, logic cm, logic cl);
		verdict_t         v;
		logic [NUM_W-1:0] nxt;
		int               idx;
		int               i;
		v.status       = ST_ACCEPTED;
		v.next_seq     = '0;
		v.got_seq      = '0;
		v.stored_epoch = '0;
		v.prior_seq    = '0;
		v.was_closed   = strm_closed;
		if (strm_closed) begin
			if (closer_valid && closer_key == key && closer_epoch == ep && closer_seq == sq) begin
				v.status    = ST_DUPLICATE;
				v.prior_seq = sq;
			end else begin
				v.status = ST_CLOSED;
			end
		end else begin
			idx = lookup_slot(key);
			if (idx < 0) begin
				if (sq != '0) begin
					v.status  = ST_GAP;
					v.got_seq = sq;
				end
			end else if (ep < tbl_epoch[idx]) begin
				v.status       = ST_STALE;
				v.stored_epoch = tbl_epoch[idx];
			end else if (ep > tbl_epoch[idx]) begin
				if (sq != '0)
					v.status = ST_BAD_EPOCH_SEQ;
			end else if (sq <= tbl_last[idx]) begin
				v.status    = ST_DUPLICATE;
				v.prior_seq = tbl_last[idx];
			end else begin
				nxt = tbl_last[idx] + 1'b1;
				if (sq != nxt) begin
					v.status   = ST_GAP;
					v.next_seq = nxt;
					v.got_seq  = sq;
				end
			end
			if (v.status == ST_ACCEPTED && (cm || cl)) begin
				if (idx < 0) begin
					// lowest free entry
					for (i = DEPTH - 1; i >= 0; i--)
						if (!tbl_valid[i])
							idx = i;
					if (idx >= 0) begin
						tbl_valid[idx] = 1'b1;
						tbl_key[idx]   = key;
					end
				end
				if (idx < 0) begin
					v.status = ST_FULL;
				end else begin
					tbl_epoch[idx] = ep;
					tbl_last[idx]  = sq;
					if (cl) begin
						strm_closed  = 1'b1;
						closer_valid = 1'b1;
						closer_key   = key;
						closer_epoch = ep;
						closer_seq   = sq;
					end
				end
			end
		end
		v.now_closed = strm_closed;
		return v;
	endfunction

	task automatic report_error(string msg);
		$display("MISMATCH at %0t ns: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [NUM_W-1:0] got, logic [NUM_W-1:0] want);
		if (got !== want)
			report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// one transfer; entered and left just after a falling edge
	task automatic send_write(logic [KEY_W-1:0] key, logic [NUM_W-1:0] ep,
			logic [NUM_W-1:0] sq, logic cm, logic cl);
		if ($urandom_range(99) < idle_pct)
			repeat ($urandom_range(1, 20)) @(negedge clk);
		producer_key  = key;
		epoch         = ep;
		seq           = sq;
		commit        = cm;
		close_request = cl;
		start         = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		verdicts_due.push_back(judge_write(key, ep, sq, cm, cl));
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic wait_drained();
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);
	endtask

	// mostly in-order writes, some duplicates, gaps, stale and bad epochs, some noise
	task automatic send_random(bit fresh_keys);
		logic [KEY_W-1:0] key;
		logic [NUM_W-1:0] ep;
		logic [NUM_W-1:0] sq;
		logic [NUM_W-1:0] last;
		logic             cm;
		logic             cl;
		int               idx;
		int               pick;
		key = key_pool[$urandom_range(key_pool.size() - 1)];
		if (fresh_keys && $urandom_range(19) == 0)
			key = $urandom();
		idx  = lookup_slot(key);
		pick = $urandom_range(99);
		cm   = ($urandom_range(9) != 0);
		cl   = 1'b0;
		if (idx < 0) begin
			ep = NUM_W'($urandom_range(9));
			sq = '0;
			if (pick >= 95) begin
				ep = rand_num();
				sq = rand_num();
			end else if (pick >= 80) begin
				sq = NUM_W'($urandom_range(1, 50));
				cl = 1'($urandom_range(1));
			end
		end else begin
			ep   = tbl_epoch[idx];
			last = tbl_last[idx];
			if (pick >= 78 && pick < 86 && last > NUM_MAX - 64)
				pick = 70;
			if (pick >= 86 && pick < 92 && ep == '0)
				pick = 70;
			if (pick < 60) begin
				sq = last + 1'b1;
			end else if (pick < 70) begin
				ep = ep + NUM_W'($urandom_range(1, 3));
				sq = '0;
			end else if (pick < 78) begin
				sq = (last > 2) ? last - NUM_W'($urandom_range(2)) : '0;
				cl = 1'($urandom_range(1));
			end else if (pick < 86) begin
				sq = last + NUM_W'($urandom_range(2, 40));
				cl = 1'($urandom_range(1));
			end else if (pick < 92) begin
				ep = (ep > 3) ? ep - NUM_W'($urandom_range(1, 3)) : '0;
				sq = last + 1'b1;
				cl = 1'($urandom_range(1));
			end else if (pick < 96) begin
				ep = ep + 1'b1;
				sq = NUM_W'($urandom_range(1, 9));
				cl = 1'($urandom_range(1));
			end else begin
				ep = rand_num();
				sq = rand_num();
			end
		end
		send_write(key, ep, sq, cm, cl);
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (verdicts_due.size() == 0) begin
				report_error("result strobe with no write outstanding");
			end else begin
				want = verdicts_due.pop_front();
				check_field("status", NUM_W'(status), NUM_W'(want.status));
				check_field("next_seq", next_seq, want.next_seq);
				check_field("got_seq", got_seq, want.got_seq);
				check_field("stored_epoch", stored_epoch, want.stored_epoch);
				check_field("prior_seq", prior_seq, want.prior_seq);
				check_field("was_closed", NUM_W'(was_closed), NUM_W'(want.was_closed));
				check_field("now_closed", NUM_W'(now_closed), NUM_W'(want.now_closed));
			end
		end
	end

	task automatic test_new_producer();
		send_write('1, '0, NUM_MAX, 1'b1, 1'b0);
		send_write('1, 63'd5, '0, 1'b0, 1'b0);
		send_write('1, 63'd5, 63'd1, 1'b1, 1'b0);
		send_write('1, 63'd5, '0, 1'b1, 1'b0);
	endtask

	task automatic test_sequence_order();
		send_write('1, 63'd5, 63'd1, 1'b0, 1'b0);
		send_write('1, 63'd5, 63'd1, 1'b1, 1'b0);
		send_write('1, 63'd5, 63'd1, 1'b1, 1'b0);
		send_write('1, 63'd5, '0, 1'b1, 1'b0);
		send_write('1, 63'd5, 63'd3, 1'b1, 1'b0);
		send_write('1, 63'd5, NUM_MAX, 1'b1, 1'b0);
	endtask

	task automatic test_epoch_rules();
		send_write('1, 63'd4, 63'd2, 1'b1, 1'b0);
		send_write('1, '0, '0, 1'b1, 1'b0);
		send_write('1, 63'd6, 63'd2, 1'b1, 1'b0);
		send_write('1, NUM_MAX, NUM_MAX, 1'b1, 1'b0);
		send_write('1, NUM_MAX, '0, 1'b1, 1'b0);
		send_write('1, NUM_MAX - 1'b1, '0, 1'b1, 1'b0);
	endtask

	task automatic test_rejected_close();
		send_write('0, '0, '0, 1'b1, 1'b0);
		send_write('0, '0, 63'd5, 1'b0, 1'b1);
		send_write('0, '0, '0, 1'b0, 1'b1);
	endtask

	task automatic test_random_traffic(int n, int pct, bit fresh_keys);
		int i;
		idle_pct = pct;
		for (i = 0; i < n; i++)
			send_random(fresh_keys);
		wait_drained();
	endtask

	task automatic test_table_full();
		idle_pct = 23;
		while (entries_used() < DEPTH)
			send_write($urandom(), NUM_W'($urandom_range(9)), '0, 1'b1, 1'b0);
		send_write($urandom(), 63'd3, '0, 1'b0, 1'b0);
		send_write($urandom(), 63'd3, '0, 1'b1, 1'b1);
		send_write($urandom(), 63'd3, '0, 1'b1, 1'b0);
		send_write($urandom(), 63'd3, 63'd7, 1'b1, 1'b0);
		wait_drained();
	endtask

	task automatic test_close_stream();
		logic [KEY_W-1:0] key;
		logic [NUM_W-1:0] ep;
		logic [NUM_W-1:0] sq;
		int               idx;
		int               i;
		idle_pct = 23;
		key = key_pool[0];
		idx = lookup_slot(key);
		ep  = tbl_epoch[idx];
		sq  = tbl_last[idx] + 1'b1;
		send_write(key, ep, sq, 1'b0, 1'b1);
		send_write(key, ep, sq, 1'b1, 1'b1);
		send_write(key, ep, sq, 1'b0, 1'b0);
		send_write(key, ep, sq + 1'b1, 1'b1, 1'b0);
		send_write(key, ep + 1'b1, '0, 1'b1, 1'b1);
		send_write(key_pool[1], '0, '0, 1'b1, 1'b0);
		for (i = 0; i < 40; i++) begin
			if ($urandom_range(4) == 0)
				send_write(key, ep, sq, 1'($urandom_range(1)), 1'($urandom_range(1)));
			else
				send_random(1'b1);
		end
		wait_drained();
	endtask

	initial begin
		int i;
		arst_n        = 1'b0;
		start         = 1'b0;
		producer_key  = '0;
		epoch         = '0;
		seq           = '0;
		commit        = 1'b0;
		close_request = 1'b0;
		errors        = 0;
		cycles        = 0;
		idle_pct      = 23;
		strm_closed   = 1'b0;
		closer_valid  = 1'b0;
		closer_key    = '0;
		closer_epoch  = '0;
		closer_seq    = '0;
		for (i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i]   = '0;
			tbl_epoch[i] = '0;
			tbl_last[i]  = '0;
		end
		// ten producers beside the two directed ones, leaving room for fresh keys
		key_pool.push_back('1);
		key_pool.push_back('0);
		for (i = 0; i < 10; i++)
			key_pool.push_back($urandom());
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_new_producer();
		test_sequence_order();
		test_epoch_rules();
		test_rejected_close();
		wait_drained();
		test_random_traffic(560, 23, 1'b0);
		test_random_traffic(560, 86, 1'b0);
		test_table_full();
		test_random_traffic(560, 0, 1'b1);
		test_close_stream();

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
design/psv_pkg.sv
design/psv_cell.sv
design/producer_sequence_validator.sv
design/psv_checker.sv
tb/producer_sequence_validator_tb.sv
